### sv/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;

    // Internal count holds 0..CAPACITY; the result field is its low five bits.
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CNT_EXT_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [CNT_W-1:0] CAPACITY_CNT  = CNT_W'(CAPACITY);
    localparam logic [4:0]       CAPACITY_LOW5 = 5'(CAPACITY);

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic               push_en;
        logic               pop_en;
        logic signed [31:0] value;
    } cell_op_t;

endpackage

### sv/sorted_array_priority_queue.sv
// A result is registered and appears on the m_ side in the cycle after its input beat.
// Throughput: one beat per cycle unless m_ready stalls the output; every cell of the
// chain compares and shifts in parallel, so the queue depth does not change the rate.
// Reset (aresetn low, synchronous) empties the queue and the output stage;
// the cell contents are not cleared and are never read before being written.
module sorted_array_priority_queue
    import spq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_top_value,
    output logic [4:0]         m_count,
    output logic               m_is_empty,
    output logic               m_is_full,
    output logic [1:0]         m_status
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg;
    logic signed [31:0]  top_reg;
    logic [CNT_W-1:0]    out_count_reg;
    status_t             status_reg, status_next;

    logic                accept;
    cell_op_t            op;
    logic                is_full_now, is_empty_now;

    logic                cell_ge   [CAPACITY];
    logic signed [31:0]  cell_data [CAPACITY];
    logic signed [31:0]  cell_nxt  [CAPACITY];

    logic [CNT_EXT_W-1:0] count_ext;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign is_full_now  = (count_reg == CAPACITY_CNT);
    assign is_empty_now = (count_reg == '0);

    always_comb begin
        op.push_en  = 1'b0;
        op.pop_en   = 1'b0;
        op.value    = s_value;
        status_next = ST_DONE;
        count_next  = count_reg;
        case (s_mode)
            MODE_PUSH: begin
                if (is_full_now) begin
                    status_next = ST_PUSH_FULL;
                end else begin
                    op.push_en = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP: begin
                if (is_empty_now) begin
                    status_next = ST_POP_EMPTY;
                end else begin
                    op.pop_en  = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic               prev_ge_w;
        logic signed [31:0] prev_data_w;
        logic signed [31:0] succ_data_w;

        if (i == 0) begin : g_first
            assign prev_ge_w   = 1'b0;
            assign prev_data_w = s_value;
        end else begin : g_mid
            assign prev_ge_w   = cell_ge[i-1];
            assign prev_data_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign succ_data_w = cell_data[i];
        end else begin : g_inner
            assign succ_data_w = cell_data[i+1];
        end

        spq_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .occupied  (CNT_W'(i) < count_reg),
            .prev_ge   (prev_ge_w),
            .prev_data (prev_data_w),
            .succ_data (succ_data_w),
            .ge        (cell_ge[i]),
            .data      (cell_data[i]),
            .data_next (cell_nxt[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The head cell's next value is the new largest entry.
    always_ff @(posedge aclk) begin
        if (accept) begin
            top_reg       <= (count_next == '0) ? 32'sd0 : cell_nxt[0];
            out_count_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign count_ext   = CNT_EXT_W'(out_count_reg);
    assign m_valid     = m_valid_reg;
    assign m_top_value = top_reg;
    assign m_count     = count_ext[4:0];
    assign m_is_empty  = (out_count_reg == '0);
    assign m_is_full   = (out_count_reg == CAPACITY_CNT);
    assign m_status    = status_reg;

endmodule

### sv/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic               aclk,
    input  cell_op_t           op,
    input  logic               occupied,
    input  logic               prev_ge,
    input  logic signed [31:0] prev_data,
    input  logic signed [31:0] succ_data,
    output logic               ge,
    output logic signed [31:0] data,
    output logic signed [31:0] data_next
);

    logic signed [31:0] data_reg;

    // The chain is kept descending: this cell is where the new value lands
    // once the value is not below the entry held here (or the slot is free).
    assign ge   = !occupied || !(op.value < data_reg);
    assign data = data_reg;

    always_comb begin
        data_next = data_reg;
        if (op.push_en) begin
            if (ge) begin
                data_next = prev_ge ? prev_data : op.value;
            end
        end else if (op.pop_en) begin
            data_next = succ_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

### sv/spq_checker.sv
module spq_checker
    import spq_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic signed [31:0] s_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_top_value,
    input logic [4:0]         m_count,
    input logic               m_is_empty,
    input logic               m_is_full,
    input logic [1:0]         m_status
);

    // An empty queue reports a zero top value.
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_top_value == 32'sd0 && m_count == 5'd0)
        else $error("empty queue reports nonzero top or count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_full |-> m_count == CAPACITY_LOW5 && !m_is_empty)
        else $error("full flag disagrees with count");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PUSH_FULL |-> m_is_full)
        else $error("dropped push without a full queue");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_POP_EMPTY |-> m_is_empty)
        else $error("ignored pop without an empty queue");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value) && $stable(m_count))
        else $error("result beat changed while stalled");

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (.*);

### tb/tb.sv
module tb
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         N_RANDOM    = 750;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 8;

    typedef struct packed {
        logic signed [31:0] top;
        logic [4:0]         count;
        logic               empty;
        logic               full;
        status_t            status;
    } queue_report_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic               typed;
        queue_report_t      report;
    } op_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_top_value;
    logic [4:0]         m_count;
    logic               m_is_empty;
    logic               m_is_full;
    logic [1:0]         m_status;

    // Ascending copy of the queue contents and the reports still owed by the block.
    logic signed [31:0] sorted_vals[$];
    queue_report_t      pending_reports[$];

    int  mismatches = 0;
    int  run_cycles = 0;
    bit  send_gaps  = 1'b1;

    // Rows with typed = 1 carry a report that can be read off directly; the
    // rest are checked against the predictor.
    op_row_t op_rows [25] = '{
        '{MODE_PEEK,   32'sd0,           1'b1, '{32'sd0, 5'd0, 1'b1, 1'b0, ST_DONE}},
        '{MODE_POP,    32'sd0,           1'b1, '{32'sd0, 5'd0, 1'b1, 1'b0, ST_POP_EMPTY}},
        '{MODE_UNUSED, 32'hFFFF_FFFF,    1'b1, '{32'sd0, 5'd0, 1'b1, 1'b0, ST_DONE}},
        '{MODE_PUSH,   32'h8000_0000,    1'b1,
            '{32'h8000_0000, 5'd1, 1'b0, 1'b0, ST_DONE}},
        '{MODE_PUSH,   32'h7FFF_FFFF,    1'b1,
            '{32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0, ST_DONE}},
        '{MODE_POP,    32'h7FFF_FFFF,    1'b1,
            '{32'h8000_0000, 5'd1, 1'b0, 1'b0, ST_DONE}},
        '{MODE_POP,    32'sd0,           1'b1, '{32'sd0, 5'd0, 1'b1, 1'b0, ST_DONE}},
        '{MODE_POP,    32'sd0,           1'b1, '{32'sd0, 5'd0, 1'b1, 1'b0, ST_POP_EMPTY}},
        '{MODE_PUSH,   32'sd5,           1'b0, '0},
        '{MODE_PUSH,   -32'sd1,          1'b0, '0},
        '{MODE_PUSH,   32'sd5,           1'b0, '0},
        '{MODE_PUSH,   32'sd0,           1'b0, '0},
        '{MODE_PUSH,   32'h7FFF_FFFF,    1'b0, '0},
        '{MODE_PUSH,   32'h8000_0000,    1'b0, '0},
        '{MODE_PUSH,   -32'sd1,          1'b0, '0},
        '{MODE_PUSH,   32'sd3,           1'b0, '0},
        '{MODE_PUSH,   32'h5555_5555,    1'b0, '0},
        '{MODE_PUSH,   32'hAAAA_AAAA,    1'b0, '0},
        '{MODE_PUSH,   32'sd5,           1'b0, '0},
        '{MODE_PUSH,   32'sd2,           1'b0, '0},
        '{MODE_PUSH,   32'h7FFF_FFFF,    1'b0, '0},
        '{MODE_PUSH,   -32'sd100,        1'b0, '0},
        '{MODE_PUSH,   32'sd1,           1'b0, '0},
        '{MODE_PUSH,   32'sd0,           1'b0, '0},
        '{MODE_PUSH,   32'h1234_5678,    1'b1,
            '{32'h7FFF_FFFF, 5'd16, 1'b0, 1'b1, ST_PUSH_FULL}}
    };

    sorted_array_priority_queue u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_is_full   (m_is_full),
        .m_status    (m_status)
    );

    always #2 aclk = ~aclk;

    // Applies one operation to the local copy and returns the report it yields.
    function automatic queue_report_t apply_op(input logic [1:0] op,
                                               input logic signed [31:0] value);
        queue_report_t r;
        int            pos;
        r.status = ST_DONE;
        if (op == MODE_PUSH) begin
            if (sorted_vals.size() >= CAPACITY) begin
                r.status = ST_PUSH_FULL;
            end else begin
                // Equal values go above earlier ones, so stop at the first entry not larger.
                pos = sorted_vals.size();
                while (pos > 0 && value < sorted_vals[pos-1])
                    pos--;
                sorted_vals.insert(pos, value);
            end
        end else if (op == MODE_POP) begin
            if (sorted_vals.size() == 0)
                r.status = ST_POP_EMPTY;
            else
                void'(sorted_vals.pop_back());
        end
        r.top   = (sorted_vals.size() != 0) ? sorted_vals[$] : 32'sd0;
        r.count = 5'(sorted_vals.size());
        r.empty = (sorted_vals.size() == 0);
        r.full  = (sorted_vals.size() == CAPACITY);
        return r;
    endfunction

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_op(input logic [1:0] op, input logic signed [31:0] value,
                           input logic typed, input queue_report_t typed_report);
        queue_report_t predicted;
        while (send_gaps && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = apply_op(op, value);
        pending_reports.insert(pending_reports.size(), typed ? typed_report : predicted);
    endtask

    initial begin
        logic [1:0]         op;
        logic signed [31:0] value;
        int                 push_pct;
        int                 pick;
        s_valid <= 1'b0;
        s_mode  <= MODE_PEEK;
        s_value <= '0;
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (op_rows[k])
            send_op(op_rows[k].mode, op_rows[k].value, op_rows[k].typed,
                    op_rows[k].report);

        push_pct = 50;
        for (int i = 0; i < N_RANDOM; i++) begin
            // Swing the push share so the queue keeps running into full and empty.
            if (i % 60 == 0) begin
                pick = $urandom_range(2);
                push_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
            end
            send_gaps = !(i >= 350 && i < 500);
            if ($urandom_range(99) < push_pct) begin
                op = MODE_PUSH;
            end else begin
                pick = $urandom_range(9);
                op = (pick < 7) ? MODE_POP : (pick < 9) ? MODE_PEEK : MODE_UNUSED;
            end
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $signed($urandom_range(15)) - 32'sd8;
                2: begin
                    pick = $urandom_range(3);
                    value = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF :
                            (pick == 2) ? 32'sd0 : -32'sd1;
                end
                default: value = $urandom;
            endcase
            send_op(op, value, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, a stretch with none, and one long hold-off
    // while the sender keeps offering beats.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (rx_cycle >= 500 && rx_cycle < 700)
                m_ready <= 1'b0;
            else if (rx_cycle >= 150 && rx_cycle < 400)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        queue_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                flag_field("unexpected beat top_value", 32'h0, m_top_value);
            end else begin
                want = pending_reports.pop_front();
                if (m_top_value !== want.top)
                    flag_field("top_value", want.top, m_top_value);
                if (m_count !== want.count)
                    flag_field("count", 32'(want.count), 32'(m_count));
                if (m_is_empty !== want.empty)
                    flag_field("is_empty", 32'(want.empty), 32'(m_is_empty));
                if (m_is_full !== want.full)
                    flag_field("is_full", 32'(want.full), 32'(m_is_full));
                if (m_status !== want.status)
                    flag_field("status", 32'(want.status), 32'(m_status));
            end
        end
    end

    always @(posedge aclk) begin
        run_cycles++;
        if (run_cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
